// ===== src/windowed_sample_statistics_macros.svh =====
// Assertion macros shared by the windowed sample statistics RTL.
`ifndef WINDOWED_SAMPLE_STATISTICS_MACROS_SVH
`define WINDOWED_SAMPLE_STATISTICS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define WSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define WSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wss_pkg.sv =====
// Package: transaction types and fixed constants for the sample statistics block.
`default_nettype none

package wss_pkg;

    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 7;
    localparam int STEP_W    = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    typedef struct packed {
        logic [WORD_W-1:0] frame_number;
        logic [WORD_W-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  last_value;
        logic [WORD_W-1:0]  window_min;
        logic [WORD_W-1:0]  window_max;
        logic [WORD_W-1:0]  window_mean;
        logic [COUNT_W-1:0] valid_count;
    } stats_t;

endpackage

`default_nettype wire

// ===== src/wss_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module wss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/wss_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
`default_nettype none

module wss_div #(
    parameter int DIV_W = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DIV_W-1:0]          dividend_hi,
    input  wire logic [wss_pkg::WORD_W-1:0] dividend_lo,
    input  wire logic [DIV_W-1:0]          divisor,
    output logic                           busy,
    output logic                           last,
    output logic      [wss_pkg::WORD_W-1:0] quotient,
    output logic      [DIV_W-1:0]          remainder
);

    // dividend_hi must be below divisor so the quotient fits in 32 bits
    logic [DIV_W-1:0]            rem_reg, rem_next;
    logic [wss_pkg::WORD_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]            dsr_reg, dsr_next;
    logic [wss_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic [DIV_W:0]              shifted;
    logic                        ge;

    assign shifted = {rem_reg, quo_reg[wss_pkg::WORD_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign last    = busy_reg && (cnt_reg == {wss_pkg::STEP_W{1'b1}});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend_hi;
            quo_next  = dividend_lo;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(shifted - {1'b0, dsr_reg}) : shifted[DIV_W-1:0];
            quo_next = {quo_reg[wss_pkg::WORD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/wss_acc.sv =====
// Scan accumulator: min, max, sum and count of nonzero ring entries.
`default_nettype none

module wss_acc #(
    parameter int CNT_W = 7
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  clear,
    input  wire logic                                  en,
    input  wire logic [wss_pkg::WORD_W-1:0]            value,
    output logic      [wss_pkg::WORD_W-1:0]            min_val,
    output logic      [wss_pkg::WORD_W-1:0]            max_val,
    output logic      [wss_pkg::WORD_W+CNT_W-1:0]      sum,
    output logic      [CNT_W-1:0]                      count
);

    localparam int SUM_W = wss_pkg::WORD_W + CNT_W;

    logic [wss_pkg::WORD_W-1:0] min_reg, min_next;
    logic [wss_pkg::WORD_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (clear)
        begin
            min_next   = '1;
            max_next   = '0;
            sum_next   = '0;
            count_next = '0;
        end
        else if (en && (value != '0))
        begin
            if (value < min_reg)
            begin
                min_next = value;
            end
            if (value > max_reg)
            begin
                max_next = value;
            end
            sum_next   = sum_reg + SUM_W'(value);
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        sum_reg <= sum_next;
    end

    assign min_val = min_reg;
    assign max_val = max_reg;
    assign sum     = sum_reg;
    assign count   = count_reg;

endmodule

`default_nettype wire

// ===== src/windowed_sample_statistics.sv =====
// Top level: sliding-window min, max, mean and count over a ring of samples.
//
//  channel | dir | valid       | stall       | payload
//  --------+-----+-------------+-------------+------------------------------
//  item    | in  | item_valid  | item_stall  | item  (frame_number, sample)
//  stats   | out | stats_valid | stats_stall | stats (last, min, max, mean, n)
//
// After reset a clearing pass writes zero to every ring slot, with item_stall
// held high throughout.
// One transaction steps through accept, write, one ring read per cycle, drain,
// divider start, a full divider run for the mean, and result load.
// A depth that is not a power of two adds one more run of the same divider,
// reducing frame_number to a slot first.
// A stalled result holds the sequencer at its final load; no new transaction meanwhile.
`default_nettype none

`include "windowed_sample_statistics_macros.svh"

module windowed_sample_statistics #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire wss_pkg::item_t  item,
    output logic                 stats_valid,
    input  wire logic            stats_stall,
    output wss_pkg::stats_t      stats
);

    localparam int  ADDR_W  = $clog2(HISTORY_DEPTH);
    localparam int  CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int  SUM_W   = wss_pkg::WORD_W + CNT_W;
    localparam int  CW      = (CNT_W > wss_pkg::COUNT_W) ? CNT_W : wss_pkg::COUNT_W;
    localparam bit  IS_POW2 = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(HISTORY_DEPTH - 1);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b0_0000_0001,
        ST_IDLE   = 9'b0_0000_0010,
        ST_MOD    = 9'b0_0000_0100,
        ST_WRITE  = 9'b0_0000_1000,
        ST_SCAN   = 9'b0_0001_0000,
        ST_TAIL   = 9'b0_0010_0000,
        ST_DSTART = 9'b0_0100_0000,
        ST_DIV    = 9'b0_1000_0000,
        ST_FLUSH  = 9'b1_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next;
    logic [ADDR_W-1:0]          slot_reg, slot_next;
    logic [wss_pkg::WORD_W-1:0] last_reg, last_next;
    logic                       rd_pend_reg;
    wss_pkg::stats_t            stats_reg, stats_next;
    logic                       stats_valid_reg, stats_valid_next;

    // ring port
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [wss_pkg::WORD_W-1:0] ram_wdata;
    logic [wss_pkg::WORD_W-1:0] ram_rdata;

    // scan accumulator
    logic                       acc_clear;
    logic [wss_pkg::WORD_W-1:0] acc_min;
    logic [wss_pkg::WORD_W-1:0] acc_max;
    logic [SUM_W-1:0]           acc_sum;
    logic [CNT_W-1:0]           acc_count;

    // shared divider
    logic                       div_start;
    logic                       div_busy;
    logic                       div_last;
    logic [CNT_W-1:0]           div_hi;
    logic [wss_pkg::WORD_W-1:0] div_lo;
    logic [CNT_W-1:0]           div_dsr;
    logic [wss_pkg::WORD_W-1:0] div_quo;
    logic [CNT_W-1:0]           div_rem;

    logic [CW-1:0]              count_ext;
    logic                       out_free;

    wss_ram #(
        .WIDTH (wss_pkg::WORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    wss_acc #(
        .CNT_W (CNT_W)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (acc_clear),
        .en      (rd_pend_reg),
        .value   (ram_rdata),
        .min_val (acc_min),
        .max_val (acc_max),
        .sum     (acc_sum),
        .count   (acc_count)
    );

    wss_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (div_hi),
        .dividend_lo (div_lo),
        .divisor     (div_dsr),
        .busy        (div_busy),
        .last        (div_last),
        .quotient    (div_quo),
        .remainder   (div_rem)
    );

    // Divider operands: frame / depth when a transaction is taken, else sum / count.
    // Whenever the count is nonzero the sum's upper part is below it, so the mean fits 32 bits.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            div_hi  = '0;
            div_lo  = item.frame_number;
            div_dsr = CNT_W'(HISTORY_DEPTH);
        end
        else
        begin
            div_hi  = acc_sum[SUM_W-1:wss_pkg::WORD_W];
            div_lo  = acc_sum[wss_pkg::WORD_W-1:0];
            div_dsr = acc_count;
        end
    end

    // Ring write: zeros during the clearing pass, the new sample otherwise.
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : last_reg;
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_waddr = idx_reg;
        end
        else if (IS_POW2)
        begin
            ram_waddr = slot_reg;
        end
        else
        begin
            ram_waddr = div_rem[ADDR_W-1:0];
        end
    end

    assign out_free   = !stats_valid_reg || !stats_stall;
    assign count_ext  = CW'(acc_count);
    assign item_stall = (state_reg != ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        slot_next        = slot_reg;
        last_next        = last_reg;
        stats_next       = stats_reg;
        stats_valid_next = stats_valid_reg && stats_stall;
        div_start        = 1'b0;
        acc_clear        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    last_next = item.sample_value;
                    slot_next = item.frame_number[ADDR_W-1:0];
                    if (IS_POW2)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                acc_clear  = 1'b1;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                // last ring word lands in the accumulator here
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    stats_next.last_value = last_reg;
                    if (acc_count == '0)
                    begin
                        stats_next.window_min  = '0;
                        stats_next.window_max  = '0;
                        stats_next.window_mean = '0;
                    end
                    else
                    begin
                        stats_next.window_min  = acc_min;
                        stats_next.window_max  = acc_max;
                        stats_next.window_mean = div_quo;
                    end
                    stats_next.valid_count = (count_ext > CW'(wss_pkg::COUNT_MAX))
                                           ? wss_pkg::COUNT_MAX
                                           : wss_pkg::COUNT_W'(count_ext);
                    stats_valid_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            idx_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            stats_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            rd_pend_reg     <= (state_reg == ST_SCAN);
            stats_valid_reg <= stats_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        last_reg  <= last_next;
        stats_reg <= stats_next;
    end

    assign stats_valid = stats_valid_reg;
    assign stats       = stats_reg;

    // Checks
    `WSS_ASSERT_IMP(a_result_from_flush, $rose(stats_valid_reg), $past(state_reg == ST_FLUSH), "result loaded outside flush")
    `WSS_ASSERT_IMP(a_div_runs_in_div, (state_reg == ST_DIV) || (state_reg == ST_MOD), div_busy, "divider idle while awaited")
    `WSS_ASSERT_IMP(a_count_bound, 1'b1, 32'(acc_count) <= 32'(HISTORY_DEPTH), "nonzero count beyond depth")
    `WSS_ASSERT_IMP(a_min_le_max, (state_reg == ST_FLUSH) && (acc_count != '0), acc_min <= acc_max, "window min above max")
    `WSS_ASSERT_NXT(a_scan_follows_write, state_reg == ST_WRITE, (state_reg == ST_SCAN) && (idx_reg == '0), "scan did not start at slot zero")

endmodule

`default_nettype wire

// ===== tb/sv/windowed_sample_statistics_tb.sv =====
// Testbench for windowed_sample_statistics: directed table, then random frame runs, checked by a predictor.
module windowed_sample_statistics_tb;
    import wss_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 880;
    // The limit is several times the slowest legal run, in which every item meets a
    // full transaction, the longest idle gap and the longest stall.
    localparam int CYCLE_LIMIT  = 1_500_000;
    // Settling time after the last result, a bit more than one transaction.
    localparam int DRAIN_CYCLES = 150;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // One row of the directed table. Where typed is set, want is the hand-worked
    // result and is expected as it stands; otherwise the predictor supplies it.
    typedef struct {
        item_t  it;
        bit     typed;
        stats_t want;
    } row_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   item_valid  = 1'b0;
    logic   item_stall;
    item_t  item        = '0;
    logic   stats_valid;
    logic   stats_stall = 1'b0;
    stats_t stats;

    // Predictor state: its own copy of the sample ring.
    logic [WORD_W-1:0] window_ring [DEPTH];
    // Expected results, oldest first.
    stats_t pending_stats [$];
    row_t   directed_rows [$];
    int     mismatches   = 0;
    int     cycle_count  = 0;
    // While set, neither side idles: back-to-back transactions and no stalls.
    bit     steady_phase = 1'b0;
    int     stall_left   = 0;

    windowed_sample_statistics #(
        .HISTORY_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .stats_valid(stats_valid),
        .stats_stall(stats_stall),
        .stats      (stats)
    );

    always #10 clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write the sample into its slot, then scan the whole ring. Zero entries are
    // empty; the sum is held in 64 bits so the mean cannot overflow.
    function automatic stats_t predict_window_stats(item_t it);
        stats_t            res;
        logic [63:0]       total;
        int                n;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        total = '0;
        n     = 0;
        lo    = ALL_ONES;
        hi    = '0;
        window_ring[it.frame_number % DEPTH] = it.sample_value;
        foreach (window_ring[i])
        begin
            if (window_ring[i] != '0)
            begin
                n++;
                total += 64'(window_ring[i]);
                if (window_ring[i] < lo)
                    lo = window_ring[i];
                if (window_ring[i] > hi)
                    hi = window_ring[i];
            end
        end
        res.last_value = it.sample_value;
        if (n == 0)
        begin
            res.window_min  = '0;
            res.window_max  = '0;
            res.window_mean = '0;
        end
        else
        begin
            res.window_min  = lo;
            res.window_max  = hi;
            res.window_mean = WORD_W'(total / 64'(n));
        end
        res.valid_count = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        mismatches++;
        $display("cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
    endtask

    // Mostly short idles, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Sample mix: empty, extremes, sub-millisecond, typical frame times, noise.
    function automatic logic [WORD_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return WORD_W'(1);
            3:       return ALL_ONES - $urandom_range(0, 255);
            4:       return $urandom_range(1, 32'h0000_FFFF);
            5, 6:    return 32'h0010_0000 + $urandom_range(0, 32'h0010_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_row(logic [WORD_W-1:0] frame, logic [WORD_W-1:0] sample,
                                    bit typed, stats_t want);
        row_t r;
        r.it.frame_number = frame;
        r.it.sample_value = sample;
        r.typed           = typed;
        r.want            = want;
        directed_rows     = {directed_rows, r};
    endfunction

    // Present one transaction after an optional idle and hold it until taken.
    // The expectation is recorded at the accepting edge, in acceptance order.
    task automatic send_item(item_t it, bit typed, stats_t want);
        int gap;
        gap = steady_phase ? 0 : idle_length();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        if (typed)
        begin
            void'(predict_window_stats(it));
            pending_stats = {pending_stats, want};
        end
        else
            pending_stats = {pending_stats, predict_window_stats(it)};
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stats.size() != 0);
    endtask

    // Receiver back-pressure: runs of stall or no stall of random length.
    always @(posedge clk)
    begin
        if (!rst_n || steady_phase)
        begin
            stats_stall <= 1'b0;
            stall_left  = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else
        begin
            stats_stall <= ($urandom_range(0, 2) == 0);
            stall_left  = idle_length();
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        stats_t want;
        if (rst_n && stats_valid === 1'b1 && !stats_stall)
        begin
            if (pending_stats.size() == 0)
                report_mismatch("result with nothing outstanding, last_value",
                                stats.last_value, '0);
            else
            begin
                want = pending_stats.pop_front();
                if (stats.last_value !== want.last_value)
                    report_mismatch("last_value", stats.last_value, want.last_value);
                if (stats.window_min !== want.window_min)
                    report_mismatch("window_min", stats.window_min, want.window_min);
                if (stats.window_max !== want.window_max)
                    report_mismatch("window_max", stats.window_max, want.window_max);
                if (stats.window_mean !== want.window_mean)
                    report_mismatch("window_mean", stats.window_mean, want.window_mean);
                if (stats.valid_count !== want.valid_count)
                    report_mismatch("valid_count", 32'(stats.valid_count),
                                    32'(want.valid_count));
            end
        end
    end

    initial
    begin : stimulus
        item_t             it;
        int                sent;
        int                kind;
        int                run;
        logic [WORD_W-1:0] frame_ctr;
        logic [WORD_W-1:0] burst_value;

        foreach (window_ring[i])
            window_ring[i] = '0;

        // Directed table. Hand-worked rows: the empty window straight after reset,
        // a single full-scale sample, a zero sample clearing the only entry, a sum
        // that overflows 32 bits, and a truncated mean.
        add_row(32'h0000_0000, 32'h0000_0000, 1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 7'd0});
        add_row(ALL_ONES,      ALL_ONES,      1'b1,
                {ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 7'd1});
        add_row(32'd127,       32'h0000_0000, 1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 7'd0});
        add_row(32'd0,         32'h0000_0001, 1'b1, {32'h1, 32'h1, 32'h1, 32'h1, 7'd1});
        add_row(32'd1,         ALL_ONES,      1'b1,
                {ALL_ONES, 32'h1, ALL_ONES, 32'h8000_0000, 7'd2});
        add_row(32'd2,         ALL_ONES,      1'b1,
                {ALL_ONES, 32'h1, ALL_ONES, 32'hAAAA_AAAA, 7'd3});
        // Slot selection from high and alternating frame bits; predicted.
        add_row(32'h8000_0040, 32'h0001_0000, 1'b0, '0);
        add_row(32'h7FFF_FFFF, 32'h0000_8000, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(32'h1234_5678, 32'hDEAD_BEEF, 1'b0, '0);
        // Zero samples emptying every occupied slot; the window ends up empty.
        add_row(32'hFFFF_FFC0, 32'h0000_0000, 1'b0, '0);
        add_row(32'h0000_0041, 32'h0000_0000, 1'b0, '0);
        add_row(32'hC000_0002, 32'h0000_0000, 1'b0, '0);
        add_row(32'd63,        32'h0000_0000, 1'b0, '0);
        add_row(32'd42,        32'h0000_0000, 1'b0, '0);
        add_row(32'd21,        32'h0000_0000, 1'b0, '0);
        add_row(32'd56,        32'h0000_0000, 1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 7'd0});
        // Mean of 2 and 3 truncates to 2; then a zero sample on a live slot.
        add_row(32'd10,        32'h0000_0002, 1'b1, {32'h2, 32'h2, 32'h2, 32'h2, 7'd1});
        add_row(32'd11,        32'h0000_0003, 1'b1, {32'h3, 32'h2, 32'h3, 32'h2, 7'd2});
        add_row(32'hFFFF_FFCB, 32'h0000_0000, 1'b1, {32'h0, 32'h2, 32'h2, 32'h2, 7'd1});

        // Reset first; the block then runs its ring-clearing pass with
        // item_stall high, which the sender simply waits out.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        wait_for_results();

        // Random part: mostly runs of consecutive frames, as a renderer would
        // produce, so the ring fills, saturates and drains; the rest is noise.
        frame_ctr = $urandom();
        sent      = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind         = $urandom_range(0, 19);
            steady_phase <= ($urandom_range(0, 7) == 0);
            burst_value  = 32'h0010_0000 + $urandom_range(0, 32'h0001_0000);
            case (kind)
                11, 12:  run = $urandom_range(DEPTH, DEPTH + 8);
                13, 14:  run = $urandom_range(8, DEPTH + 4);
                15, 16, 17: run = $urandom_range(1, 20);
                18:      run = $urandom_range(1, DEPTH);
                19:      run = 0;
                default: run = $urandom_range(1, 80);
            endcase
            if (kind == 19)
                wait_for_results();
            for (int k = 0; k < run; k++)
            begin
                it.frame_number = frame_ctr;
                case (kind)
                    // Near full scale everywhere: count reaches the depth and the
                    // sum goes well past 32 bits.
                    11, 12:     it.sample_value = ALL_ONES - $urandom_range(0, 1);
                    // Dropped frames: zero samples drain the window.
                    13, 14:     it.sample_value = '0;
                    15, 16, 17:
                    begin
                        it.frame_number = $urandom();
                        it.sample_value = random_sample();
                    end
                    18:         it.sample_value = burst_value;
                    default:    it.sample_value = random_sample();
                endcase
                send_item(it, 1'b0, '0);
                frame_ctr++;
                sent++;
            end
        end

        item_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/wss_pkg.sv
src/wss_ram.sv
src/wss_div.sv
src/wss_acc.sv
src/windowed_sample_statistics.sv
tb/sv/windowed_sample_statistics_tb.sv
